>>> design/fxalu_pkg.sv
// shared types, codes and constants of the q24.8 fixed-point alu
`default_nettype none
package fxalu_pkg;

	localparam int WordBits = 32;
	localparam int FracBits = 8;
	// quotient bits of the divider, one per cell
	localparam int NumBits = WordBits + FracBits;

	localparam logic [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
	localparam logic [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};

	typedef enum logic [3:0] {
		ACT_ADD      = 4'd0,
		ACT_SUB      = 4'd1,
		ACT_MUL      = 4'd2,
		ACT_DIV      = 4'd3,
		ACT_GT       = 4'd4,
		ACT_LT       = 4'd5,
		ACT_GE       = 4'd6,
		ACT_LE       = 4'd7,
		ACT_EQ       = 4'd8,
		ACT_NE       = 4'd9,
		ACT_MIN      = 4'd10,
		ACT_MAX      = 4'd11,
		ACT_INC      = 4'd12,
		ACT_DEC      = 4'd13,
		ACT_FROM_INT = 4'd14,
		ACT_TO_INT   = 4'd15
	} action_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	// result that rides along the divider chain
	typedef struct packed {
		logic                is_div;
		logic                neg;
		logic [WordBits-1:0] value;
		logic                cmp;
		logic [1:0]          status;
	} side_t;

	// divider working set handed from cell to cell
	typedef struct packed {
		logic [WordBits-1:0] rem;
		logic [NumBits-1:0]  num;
		logic [NumBits-1:0]  quo;
		logic [WordBits-1:0] den;
	} div_t;

	function automatic logic [WordBits-1:0] mag(input logic [WordBits-1:0] x);
		mag = x[WordBits-1] ? (~x + 1'b1) : x;
	endfunction

endpackage
`default_nettype wire

>>> design/fixed_point_q24_8_alu.sv
// top level of the q24.8 fixed-point alu: front stages, divider chain, output register
// One item enters per cycle unless stalled, then passes two operand stages (multiplier
// product, then all single-step actions), a chain of 40 division cells that each settle
// one quotient bit of the 40-bit quotient, and the output register where a quotient is
// rounded and saturated. Every action travels the full chain so results leave in order.
// A stall on the output side holds the whole pipeline, bubbles included.
`default_nettype none
module fixed_point_q24_8_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // operand_a, operand_b
	input  wire logic [3:0]  s_axis_tuser,   // action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // result_value
	output logic [2:0]       m_axis_tuser    // compare_true, status
);

	logic adv;
	logic valid_c [fxalu_pkg::NumBits+1];
	fxalu_pkg::side_t side_c [fxalu_pkg::NumBits+1];
	fxalu_pkg::div_t  div_c  [fxalu_pkg::NumBits+1];

	logic                               m_valid_q;
	logic [fxalu_pkg::WordBits-1:0]     value_q;
	logic                               cmp_q;
	logic [1:0]                         status_q;

	fxalu_pkg::side_t                   last_side;
	fxalu_pkg::div_t                    last_div;
	logic                               rnd;
	logic [fxalu_pkg::NumBits:0]        q_rnd;
	logic [fxalu_pkg::NumBits:0]        q_lim;
	logic [fxalu_pkg::WordBits-1:0]     value_d;
	logic [1:0]                         status_d;

	assign adv           = !m_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	fxalu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.in_a      (s_axis_tdata[31:0]),
		.in_b      (s_axis_tdata[63:32]),
		.valid_s2  (valid_c[0]),
		.side_s2   (side_c[0]),
		.div_s2    (div_c[0])
	);

	for (genvar i = 0; i < fxalu_pkg::NumBits; i++) begin : g_cell
		fxalu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (valid_c[i]),
			.in_side  (side_c[i]),
			.in_div   (div_c[i]),
			.valid_q  (valid_c[i+1]),
			.side_q   (side_c[i+1]),
			.div_q    (div_c[i+1])
		);
	end

	always_comb begin
		last_side = side_c[fxalu_pkg::NumBits];
		last_div  = div_c[fxalu_pkg::NumBits];
		// round half away from zero: twice the remainder against the divisor
		rnd   = {last_div.rem, 1'b0} >= {1'b0, last_div.den};
		q_rnd = {1'b0, last_div.quo} + {{fxalu_pkg::NumBits{1'b0}}, rnd};
		q_lim = {{(fxalu_pkg::NumBits-fxalu_pkg::WordBits+1){1'b0}}, fxalu_pkg::WordMax}
			+ {{fxalu_pkg::NumBits{1'b0}}, last_side.neg};
		value_d  = last_side.value;
		status_d = last_side.status;
		if (last_side.is_div) begin
			if (q_rnd > q_lim) begin
				value_d  = last_side.neg ? fxalu_pkg::WordMin : fxalu_pkg::WordMax;
				status_d = fxalu_pkg::ST_SAT;
			end else begin
				value_d = last_side.neg ? (~q_rnd[fxalu_pkg::WordBits-1:0] + 1'b1)
					: q_rnd[fxalu_pkg::WordBits-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_c[fxalu_pkg::NumBits];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q  <= value_d;
			cmp_q    <= last_side.cmp;
			status_q <= status_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = value_q;
	assign m_axis_tuser  = {status_q, cmp_q};

	// a true comparison carries a zero value and no status
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && cmp_q |-> value_q == '0 && status_q == fxalu_pkg::ST_OK)
		else $error("comparison result carries value or status");

	// saturation and division by zero always land on a word limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (status_q == fxalu_pkg::ST_SAT || status_q == fxalu_pkg::ST_DIVZ)
		|-> value_q == fxalu_pkg::WordMax || value_q == fxalu_pkg::WordMin)
		else $error("saturated result is not a word limit");

	// an item taken in enters the front stage on the next edge
	a_take_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> u_front.valid_s1)
		else $error("front stage lost an item");

endmodule
`default_nettype wire

>>> design/fxalu_front.sv
// operand stages: multiplier, all single-step actions and divider setup
`default_nettype none
module fxalu_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire logic                               in_valid,
	input  wire logic [3:0]                         in_action,
	input  wire logic [fxalu_pkg::WordBits-1:0]     in_a,
	input  wire logic [fxalu_pkg::WordBits-1:0]     in_b,
	output logic                                    valid_s2,
	output fxalu_pkg::side_t                        side_s2,
	output fxalu_pkg::div_t                         div_s2
);

	logic                                valid_s1;
	logic [3:0]                          act_s1;
	logic [fxalu_pkg::WordBits-1:0]      a_s1;
	logic [fxalu_pkg::WordBits-1:0]      b_s1;
	logic [2*fxalu_pkg::WordBits-1:0]    prod_s1;

	logic [fxalu_pkg::WordBits:0]        a33;
	logic [fxalu_pkg::WordBits:0]        opnd;
	logic [fxalu_pkg::WordBits:0]        s33;
	logic [2*fxalu_pkg::WordBits-fxalu_pkg::FracBits:0] m_rnd;
	logic [2*fxalu_pkg::WordBits-fxalu_pkg::FracBits:0] m_lim;
	logic                                neg;
	logic                                lt;
	logic                                gt;
	logic                                fits_int;
	fxalu_pkg::side_t                    side_d;
	fxalu_pkg::div_t                     div_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= in_action;
			a_s1    <= in_a;
			b_s1    <= in_b;
			prod_s1 <= fxalu_pkg::mag(in_a) * fxalu_pkg::mag(in_b);
			side_s2 <= side_d;
			div_s2  <= div_d;
		end
	end

	always_comb begin
		a33  = {a_s1[fxalu_pkg::WordBits-1], a_s1};
		opnd = (act_s1 == fxalu_pkg::ACT_INC || act_s1 == fxalu_pkg::ACT_DEC)
			? {{fxalu_pkg::WordBits{1'b0}}, 1'b1} : {b_s1[fxalu_pkg::WordBits-1], b_s1};
		s33  = (act_s1 == fxalu_pkg::ACT_SUB || act_s1 == fxalu_pkg::ACT_DEC)
			? a33 - opnd : a33 + opnd;
		neg  = a_s1[fxalu_pkg::WordBits-1] ^ b_s1[fxalu_pkg::WordBits-1];
		lt   = $signed(a_s1) < $signed(b_s1);
		gt   = $signed(b_s1) < $signed(a_s1);
		// rounding half away from zero on the magnitude product
		m_rnd = {1'b0, prod_s1[2*fxalu_pkg::WordBits-1:fxalu_pkg::FracBits]}
			+ {{(2*fxalu_pkg::WordBits-fxalu_pkg::FracBits){1'b0}},
			prod_s1[fxalu_pkg::FracBits-1]};
		m_lim = {{(fxalu_pkg::WordBits-fxalu_pkg::FracBits+1){1'b0}}, fxalu_pkg::WordMax}
			+ {{(2*fxalu_pkg::WordBits-fxalu_pkg::FracBits){1'b0}}, neg};
		// from_int fits when the bits shifted out all match the sign
		fits_int = (a_s1[fxalu_pkg::WordBits-1:fxalu_pkg::WordBits-fxalu_pkg::FracBits-1]
			== {(fxalu_pkg::FracBits+1){1'b0}})
			|| (a_s1[fxalu_pkg::WordBits-1:fxalu_pkg::WordBits-fxalu_pkg::FracBits-1]
			== {(fxalu_pkg::FracBits+1){1'b1}});

		side_d = '0;
		div_d  = '0;
		case (act_s1)
			fxalu_pkg::ACT_ADD, fxalu_pkg::ACT_SUB, fxalu_pkg::ACT_INC,
			fxalu_pkg::ACT_DEC: begin
				if (s33[fxalu_pkg::WordBits] != s33[fxalu_pkg::WordBits-1]) begin
					side_d.value  = s33[fxalu_pkg::WordBits]
						? fxalu_pkg::WordMin : fxalu_pkg::WordMax;
					side_d.status = fxalu_pkg::ST_SAT;
				end else begin
					side_d.value = s33[fxalu_pkg::WordBits-1:0];
				end
			end
			fxalu_pkg::ACT_MUL: begin
				if (m_rnd > m_lim) begin
					side_d.value  = neg ? fxalu_pkg::WordMin : fxalu_pkg::WordMax;
					side_d.status = fxalu_pkg::ST_SAT;
				end else begin
					side_d.value = neg ? (~m_rnd[fxalu_pkg::WordBits-1:0] + 1'b1)
						: m_rnd[fxalu_pkg::WordBits-1:0];
				end
			end
			fxalu_pkg::ACT_DIV: begin
				if (b_s1 == '0) begin
					side_d.value  = a_s1[fxalu_pkg::WordBits-1]
						? fxalu_pkg::WordMin : fxalu_pkg::WordMax;
					side_d.status = fxalu_pkg::ST_DIVZ;
				end else begin
					side_d.is_div = 1'b1;
					side_d.neg    = neg;
					div_d.num     = {fxalu_pkg::mag(a_s1), {fxalu_pkg::FracBits{1'b0}}};
					div_d.den     = fxalu_pkg::mag(b_s1);
				end
			end
			fxalu_pkg::ACT_GT: side_d.cmp = gt;
			fxalu_pkg::ACT_LT: side_d.cmp = lt;
			fxalu_pkg::ACT_GE: side_d.cmp = !lt;
			fxalu_pkg::ACT_LE: side_d.cmp = !gt;
			fxalu_pkg::ACT_EQ: side_d.cmp = (a_s1 == b_s1);
			fxalu_pkg::ACT_NE: side_d.cmp = (a_s1 != b_s1);
			fxalu_pkg::ACT_MIN: side_d.value = gt ? b_s1 : a_s1;
			fxalu_pkg::ACT_MAX: side_d.value = lt ? b_s1 : a_s1;
			fxalu_pkg::ACT_FROM_INT: begin
				if (fits_int) begin
					side_d.value = {a_s1[fxalu_pkg::WordBits-fxalu_pkg::FracBits-1:0],
						{fxalu_pkg::FracBits{1'b0}}};
				end else begin
					side_d.value  = a_s1[fxalu_pkg::WordBits-1]
						? fxalu_pkg::WordMin : fxalu_pkg::WordMax;
					side_d.status = fxalu_pkg::ST_SAT;
				end
			end
			default: side_d.value = $signed(a_s1) >>> fxalu_pkg::FracBits;
		endcase
	end

endmodule
`default_nettype wire

>>> design/fxalu_cell.sv
// one restoring division step, registered, with the result riding along
`default_nettype none
module fxalu_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  fxalu_pkg::side_t      in_side,
	input  fxalu_pkg::div_t       in_div,
	output logic                  valid_q,
	output fxalu_pkg::side_t      side_q,
	output fxalu_pkg::div_t       div_q
);

	logic [fxalu_pkg::WordBits:0] trial;
	logic [fxalu_pkg::WordBits:0] diff;
	logic                         take;
	fxalu_pkg::div_t              div_d;

	always_comb begin
		trial = {in_div.rem, in_div.num[fxalu_pkg::NumBits-1]};
		take  = trial >= {1'b0, in_div.den};
		diff  = trial - {1'b0, in_div.den};
		div_d     = in_div;
		div_d.num = {in_div.num[fxalu_pkg::NumBits-2:0], 1'b0};
		div_d.quo = {in_div.quo[fxalu_pkg::NumBits-2:0], take};
		// the remainder stays below the divisor, so it fits the word
		div_d.rem = take ? diff[fxalu_pkg::WordBits-1:0] : trial[fxalu_pkg::WordBits-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q <= in_side;
			div_q  <= div_d;
		end
	end

endmodule
`default_nettype wire
